[src/pflm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pflm_pkg: shared types and codes of the page frame LRU manager
// Request and result codes, payload structs and the front-to-back command.
// ----------------------------------------------------------------------------
package pflm_pkg;

    localparam int PAGE_W = 32;
    localparam int TYPE_W = 3;
    localparam int ACT_W  = 3;
    localparam int FRM_W  = 4;
    localparam int PIN_W  = 16;
    localparam int TIME_W = 32;

    typedef enum logic [TYPE_W-1:0] {
        REQ_GET   = 3'd0,
        REQ_PIN   = 3'd1,
        REQ_UNPIN = 3'd2,
        REQ_DIRTY = 3'd3,
        REQ_FLUSH = 3'd4
    } t_req;

    typedef enum logic [ACT_W-1:0] {
        ACT_HIT    = 3'd0,
        ACT_FILL   = 3'd1,
        ACT_WB     = 3'd2,
        ACT_FAIL   = 3'd3,
        ACT_APPLY  = 3'd4,
        ACT_ABSENT = 3'd5,
        ACT_FDONE  = 3'd6
    } t_act;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [PAGE_W-1:0] page_id;
    } t_in;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [FRM_W-1:0]  frame;
        logic [PAGE_W-1:0] page_number;
        logic              last;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SEARCH,
        ST_WB,
        ST_FILL,
        ST_FLUSH,
        ST_ONE
    } t_state;

endpackage
`default_nettype wire

[src/pflm_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pflm_if: valid/ready channel carrying one packed payload
// Used for the request, the internal queue and the result channels.
// ----------------------------------------------------------------------------
interface pflm_if #(
    parameter int W = 35
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/page_frame_lru_manager.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_lru_manager: page cache frame directory with LRU and pinning
// Requests arrive on i_req (req_type, page_id) and results leave on o_res
// (action, frame, page_number, last), both valid/ready channels.
// A front stage drops unknown request types and queues up to two requests;
// the back stage executes one request at a time. A get that must replace
// scans all FRAMES frames one per cycle for the oldest unpinned frame. A
// flush visits every frame and emits a writeback for each dirty one. The
// result register holds a result while o_res stalls and the back stage
// then waits; the queue keeps taking requests until full. Reset empties
// all frames, clears pin counts, use times and the use clock.
// ----------------------------------------------------------------------------
module page_frame_lru_manager #(
    parameter int FRAMES = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pflm_if.sink      i_req,
    pflm_if.source    o_res
);
    import pflm_pkg::*;

    pflm_if #(.W($bits(t_in))) w_cmd ();

    pflm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_cmd   (w_cmd)
    );

    pflm_back #(.FRAMES(FRAMES)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid && $stable(o_res.data))
        else $error("result changed while stalled");
    a_cmd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.valid && !w_cmd.ready |=> w_cmd.valid)
        else $error("queued request lost");
`endif
endmodule
`default_nettype wire

[src/pflm_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pflm_front: request intake and classification
// Drops unknown request types and pushes the rest into a two-entry queue.
// ----------------------------------------------------------------------------
module pflm_front (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pflm_if.sink      i_req,
    pflm_if.source    o_cmd
);
    import pflm_pkg::*;

    t_in        w_in;
    logic       w_known;
    logic [1:0] r_cnt;
    logic       r_wp;
    logic       r_rp;
    t_in        r_q [2];
    logic       w_push;
    logic       w_pop;

    assign w_in    = t_in'(i_req.data);
    assign w_known = (w_in.req_type <= TYPE_W'(REQ_FLUSH));
    assign i_req.ready = (r_cnt != 2'd2);
    assign w_push  = i_req.valid && i_req.ready && w_known;
    assign w_pop   = o_cmd.valid && o_cmd.ready;
    assign o_cmd.valid = (r_cnt != 2'd0);
    assign o_cmd.data  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_in;
    end
endmodule
`default_nettype wire

[src/pflm_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pflm_back: frame directory and request execution
// Looks up pages, runs the victim search one frame a cycle, walks the frames
// for a flush and drives a registered result stage.
// ----------------------------------------------------------------------------
module pflm_back #(
    parameter int FRAMES = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pflm_if.sink      i_cmd,
    pflm_if.source    o_res
);
    import pflm_pkg::*;

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    logic [FRAMES-1:0] r_valid;
    logic [FRAMES-1:0] r_dirty;
    logic [PAGE_W-1:0] r_page [FRAMES];
    logic [PIN_W-1:0]  r_pins [FRAMES];
    logic [TIME_W-1:0] r_time [FRAMES];
    logic [TIME_W-1:0] r_clock;

    t_state r_st, n_st;
    t_in    r_cur;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_slot;
    logic          r_found;
    logic [IW-1:0] r_best;
    logic          r_has;
    logic          r_ov;
    t_out          r_out;

    logic [FRAMES-1:0] w_match;
    logic [FRAMES-1:0] w_empty;
    logic          w_hit;
    logic [IW-1:0] w_hit_idx;
    logic          w_free;
    logic [IW-1:0] w_free_idx;
    logic          w_out_free;
    logic          w_last_idx;
    logic          w_better;
    logic [IW-1:0] w_vic;
    t_out          w_emit;
    logic          w_emit_v;
    t_in           w_cmd_in;

    assign w_cmd_in    = t_in'(i_cmd.data);
    assign w_out_free = !r_ov || o_res.ready;
    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;
    assign i_cmd.ready = (r_st == ST_IDLE);
    assign w_last_idx  = (r_idx == IW'(FRAMES - 1));

    always_comb begin
        w_hit = 1'b0;
        w_hit_idx = '0;
        w_free = 1'b0;
        w_free_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            w_match[i] = r_valid[i] && (r_page[i] == r_cur.page_id);
            w_empty[i] = !r_valid[i];
            if (w_match[i]) begin
                w_hit = 1'b1;
                w_hit_idx = IW'(i);
            end
            if (w_empty[i]) begin
                w_free = 1'b1;
                w_free_idx = IW'(i);
            end
        end
    end

    assign w_better = (r_pins[r_idx] == '0) &&
                      (!r_has || (r_time[r_idx] < r_time[r_best]));
    assign w_vic = w_better ? r_idx : r_best;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:   if (i_cmd.valid) n_st = ST_LOOK;
            ST_LOOK: begin
                if (w_out_free) begin
                    priority if (r_cur.req_type == TYPE_W'(REQ_FLUSH)) n_st = ST_FLUSH;
                    else if (r_cur.req_type != TYPE_W'(REQ_GET) || w_hit) n_st = ST_IDLE;
                    else if (w_free) n_st = ST_FILL;
                    else n_st = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (w_last_idx) begin
                    priority if (!(w_better || r_has)) n_st = ST_ONE;
                    else if (r_dirty[w_vic]) n_st = ST_WB;
                    else n_st = ST_FILL;
                end
            end
            ST_WB:     if (w_out_free) n_st = ST_FILL;
            ST_FILL:   if (w_out_free) n_st = ST_IDLE;
            ST_ONE:    if (w_out_free) n_st = ST_IDLE;
            ST_FLUSH:  if (w_out_free && w_last_idx && !(r_valid[r_idx] && r_dirty[r_idx]))
                           n_st = ST_ONE;
            default:   n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        w_emit_v = 1'b0;
        w_emit = '0;
        unique case (r_st)
            ST_LOOK: begin
                if (r_cur.req_type == TYPE_W'(REQ_GET)) begin
                    if (w_hit) begin
                        w_emit_v = 1'b1;
                        w_emit.action = ACT_W'(ACT_HIT);
                        w_emit.frame = FRM_W'(w_hit_idx);
                        w_emit.last = 1'b1;
                    end
                end else if (r_cur.req_type != TYPE_W'(REQ_FLUSH)) begin
                    w_emit_v = 1'b1;
                    w_emit.last = 1'b1;
                    w_emit.action = w_hit ? ACT_W'(ACT_APPLY) : ACT_W'(ACT_ABSENT);
                    w_emit.frame = w_hit ? FRM_W'(w_hit_idx) : '0;
                end
            end
            ST_WB: begin
                w_emit_v = 1'b1;
                w_emit.action = ACT_W'(ACT_WB);
                w_emit.frame = FRM_W'(r_slot);
                w_emit.page_number = r_page[r_slot];
            end
            ST_FILL: begin
                w_emit_v = 1'b1;
                w_emit.action = ACT_W'(ACT_FILL);
                w_emit.frame = FRM_W'(r_slot);
                w_emit.page_number = r_cur.page_id;
                w_emit.last = 1'b1;
            end
            ST_FLUSH: begin
                if (r_valid[r_idx] && r_dirty[r_idx]) begin
                    w_emit_v = 1'b1;
                    w_emit.action = ACT_W'(ACT_WB);
                    w_emit.frame = FRM_W'(r_idx);
                    w_emit.page_number = r_page[r_idx];
                end
            end
            ST_ONE: begin
                w_emit_v = 1'b1;
                w_emit.last = 1'b1;
                w_emit.action = r_found ? ACT_W'(ACT_FDONE) : ACT_W'(ACT_FAIL);
            end
            default: w_emit_v = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_ov    <= 1'b0;
            r_valid <= '0;
            r_dirty <= '0;
            r_clock <= '0;
            r_has   <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                r_pins[i] <= '0;
                r_time[i] <= '0;
            end
        end else begin
            r_st <= n_st;
            if (w_emit_v && w_out_free) begin
                r_ov <= 1'b1;
                r_out <= w_emit;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_st)
                ST_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cur <= w_cmd_in;
                        if (w_cmd_in.req_type == TYPE_W'(REQ_GET))
                            r_clock <= r_clock + TIME_W'(1);
                    end
                    r_idx <= '0;
                    r_has <= 1'b0;
                end
                ST_LOOK: begin
                    if (w_out_free) begin
                        r_found <= (r_cur.req_type == TYPE_W'(REQ_FLUSH));
                        r_slot <= w_free_idx;
                        if (w_hit) begin
                            unique case (r_cur.req_type)
                                TYPE_W'(REQ_GET): begin
                                    r_time[w_hit_idx] <= r_clock;
                                    if (r_pins[w_hit_idx] != '1)
                                        r_pins[w_hit_idx] <= r_pins[w_hit_idx] + PIN_W'(1);
                                end
                                TYPE_W'(REQ_PIN): begin
                                    if (r_pins[w_hit_idx] != '1)
                                        r_pins[w_hit_idx] <= r_pins[w_hit_idx] + PIN_W'(1);
                                end
                                TYPE_W'(REQ_UNPIN): begin
                                    if (r_pins[w_hit_idx] != '0)
                                        r_pins[w_hit_idx] <= r_pins[w_hit_idx] - PIN_W'(1);
                                end
                                TYPE_W'(REQ_DIRTY): r_dirty[w_hit_idx] <= 1'b1;
                                default: ;
                            endcase
                        end
                    end
                end
                ST_SEARCH: begin
                    if (w_better) begin
                        r_best <= r_idx;
                        r_has <= 1'b1;
                    end
                    r_slot <= w_vic;
                    r_idx <= r_idx + IW'(1);
                end
                ST_FILL: begin
                    if (w_out_free) begin
                        r_valid[r_slot] <= 1'b1;
                        r_dirty[r_slot] <= 1'b0;
                        r_page[r_slot] <= r_cur.page_id;
                        r_pins[r_slot] <= PIN_W'(1);
                        r_time[r_slot] <= r_clock;
                    end
                end
                ST_FLUSH: begin
                    if (w_out_free) begin
                        r_dirty[r_idx] <= 1'b0;
                        if (!(r_valid[r_idx] && r_dirty[r_idx]))
                            r_idx <= r_idx + IW'(1);
                    end
                end
                default: r_found <= r_found;
            endcase
        end
    end
endmodule
`default_nettype wire

[verif/page_frame_lru_manager_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_lru_manager_test: self-checking testbench of the frame directory
// Drives get, pin, unpin, mark dirty, flush and unknown requests with random
// gaps on both channels, predicts every result from a local copy of the frame
// table and compares each whole result in order.
// ----------------------------------------------------------------------------
module page_frame_lru_manager_test;
    import pflm_pkg::*;

    localparam int NFR = 16;

    class frame_table_board;
        bit          fv[NFR];
        bit [31:0]   fpage[NFR];
        bit          fdirty[NFR];
        bit [15:0]   fpins[NFR];
        bit [31:0]   futime[NFR];
        bit [31:0]   uclock;
        t_out        pending[$];
        int          errors;
        int          checked;

        function int find_page(bit [31:0] pg);
            for (int i = 0; i < NFR; i++) begin
                if (fv[i] && fpage[i] == pg) return i;
            end
            return -1;
        endfunction

        function void push(t_act a, int fr, bit [31:0] pg, bit l);
            t_out r;
            r.action = a;
            r.frame = fr[3:0];
            r.page_number = pg;
            r.last = l;
            pending.push_back(r);
        endfunction

        function void note_request(t_in req);
            int s;
            bit [31:0] pg;
            pg = req.page_id;
            s = -1;
            case (req.req_type)
                REQ_GET: begin
                    uclock = uclock + 1;
                    s = find_page(pg);
                    if (s >= 0) begin
                        futime[s] = uclock;
                        if (fpins[s] != 16'hFFFF) fpins[s]++;
                        push(ACT_HIT, s, 0, 1);
                        return;
                    end
                    for (int i = 0; i < NFR && s < 0; i++) begin
                        if (!fv[i]) s = i;
                    end
                    if (s < 0) begin
                        for (int i = 0; i < NFR; i++) begin
                            if (fpins[i] == 0 && (s < 0 || futime[i] < futime[s])) s = i;
                        end
                        if (s < 0) begin
                            push(ACT_FAIL, 0, 0, 1);
                            return;
                        end
                        if (fdirty[s]) push(ACT_WB, s, fpage[s], 0);
                    end
                    fv[s] = 1;
                    fpage[s] = pg;
                    fdirty[s] = 0;
                    fpins[s] = 1;
                    futime[s] = uclock;
                    push(ACT_FILL, s, pg, 1);
                end
                REQ_PIN, REQ_UNPIN, REQ_DIRTY: begin
                    s = find_page(pg);
                    if (s < 0) begin
                        push(ACT_ABSENT, 0, 0, 1);
                        return;
                    end
                    if (req.req_type == REQ_PIN) begin
                        if (fpins[s] != 16'hFFFF) fpins[s]++;
                    end else if (req.req_type == REQ_UNPIN) begin
                        if (fpins[s] != 0) fpins[s]--;
                    end else begin
                        fdirty[s] = 1;
                    end
                    push(ACT_APPLY, s, 0, 1);
                end
                REQ_FLUSH: begin
                    for (int i = 0; i < NFR; i++) begin
                        if (fv[i] && fdirty[i]) begin
                            push(ACT_WB, i, fpage[i], 0);
                            fdirty[i] = 0;
                        end
                    end
                    push(ACT_FDONE, 0, 0, 1);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_out got);
            t_out want;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("ERROR: result %0d expected %p got %p", checked, want, got);
                end
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    pflm_if #(.W(35)) req_ch ();
    pflm_if #(.W(40)) res_ch ();
    frame_table_board board;
    int n_sent;
    int n_flush;
    int n_wb;

    page_frame_lru_manager #(.FRAMES(NFR)) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_ch.sink),
        .o_res(res_ch.source)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        req_ch.valid = 0;
        req_ch.data = '0;
        res_ch.ready = 0;
    end

    initial begin
        #2000000;
        $display("page_frame_lru_manager verification failed");
        $finish;
    end

    // Result side: random stalls, with some stretches always ready.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            board.check_result(t_out'(res_ch.data));
            if (t_act'(res_ch.data[39:37]) == ACT_WB) n_wb++;
        end
    end

    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                res_ch.ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
        end
    end

    task automatic send_request(logic [2:0] kind, logic [31:0] pg, bit no_gap = 0);
        int gap;
        t_in r;
        gap = no_gap ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            req_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        r.req_type = kind;
        r.page_id = pg;
        req_ch.valid <= 1;
        req_ch.data <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        board.note_request(r);
        n_sent++;
        if (kind == REQ_FLUSH) n_flush++;
    endtask

    function automatic logic [31:0] pick_page();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return $urandom();
        if (k == 1) return 32'hFFFFFFFF - $urandom_range(0, 1);
        return $urandom_range(0, 23);
    endfunction

    initial begin
        int kind;
        logic [31:0] pg;
        board = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: absent pages, empty flush, extremes of page numbers.
        send_request(REQ_PIN, 32'h0);
        send_request(REQ_UNPIN, 32'hFFFFFFFF);
        send_request(REQ_DIRTY, 32'h5);
        send_request(REQ_FLUSH, 32'hFFFFFFFF);
        send_request(3'd5, 32'h1);
        send_request(3'd7, 32'hFFFFFFFF);
        send_request(REQ_GET, 32'hFFFFFFFF);
        send_request(REQ_GET, 32'h0);
        send_request(REQ_GET, 32'hAAAAAAAA);
        send_request(REQ_GET, 32'h55555555);
        send_request(REQ_GET, 32'hFFFFFFFF);
        send_request(REQ_DIRTY, 32'hFFFFFFFF);
        send_request(REQ_DIRTY, 32'h0);
        send_request(REQ_PIN, 32'hAAAAAAAA);
        for (int i = 0; i < 4; i++) send_request(REQ_UNPIN, 32'hAAAAAAAA);
        send_request(REQ_FLUSH, 32'h0);

        // Random: mostly gets and page-state changes on a small page pool so
        // that hits, evictions of dirty frames and all-pinned failures occur.
        for (int n = 0; n < 200; n++) begin
            kind = $urandom_range(0, 99);
            pg = pick_page();
            if (kind < 45) send_request(REQ_GET, pg, $urandom_range(0, 4) == 0);
            else if (kind < 55) send_request(REQ_PIN, pg);
            else if (kind < 75) send_request(REQ_UNPIN, pg, $urandom_range(0, 4) == 0);
            else if (kind < 90) send_request(REQ_DIRTY, pg);
            else if (kind < 96) send_request(REQ_FLUSH, $urandom());
            else send_request(3'($urandom_range(5, 7)), pg);
        end
        req_ch.valid <= 0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Run covered %0d requests, %0d flushes, %0d writebacks, %0d results checked.",
                 n_sent, n_flush, n_wb, board.checked);
        $display("Final use clock %0d, mismatches %0d.", board.uclock, board.errors);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("page_frame_lru_manager verification clean");
        end else begin
            $display("page_frame_lru_manager verification failed");
        end
        $finish;
    end
endmodule

[files.f]
src/pflm_pkg.sv
src/pflm_if.sv
src/pflm_front.sv
src/pflm_back.sv
src/page_frame_lru_manager.sv
verif/page_frame_lru_manager_test.sv
